/* design/saw_pkg.sv */
// Shared types, codes and header checksum for the stop-and-wait multicast ACK receiver.
package saw_pkg;

    localparam logic [15:0] HDR_BYTES = 16'd22;

    localparam int FLAG_SYN_BIT   = 0;
    localparam int FLAG_START_BIT = 2;
    localparam int FLAG_DATA_BIT  = 3;
    localparam int FLAG_FIN_BIT   = 4;

    localparam logic [1:0] ACK_FLAGS_SYNACK = 2'd3;
    localparam logic [1:0] ACK_FLAGS_PLAIN  = 2'd2;

    localparam logic [15:0] ACK_WINDOW   = 16'h0001;
    localparam logic [7:0]  ACK_RESERVED = 8'h00;

    localparam logic [3:0] ACT_INVALID      = 4'd0;
    localparam logic [3:0] ACT_SYNACK       = 4'd1;
    localparam logic [3:0] ACT_START        = 4'd2;
    localparam logic [3:0] ACT_DELIVERED    = 4'd3;
    localparam logic [3:0] ACT_DUPLICATE    = 4'd4;
    localparam logic [3:0] ACT_OUT_OF_ORDER = 4'd5;
    localparam logic [3:0] ACT_EARLY_ACK    = 4'd6;
    localparam logic [3:0] ACT_FIN          = 4'd7;
    localparam logic [3:0] ACT_AFTER_FINISH = 4'd8;
    localparam logic [3:0] ACT_OTHER        = 4'd9;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic        frame_ok;
        logic        is_syn;
        logic        is_start;
        logic        is_data;
        logic        is_fin;
        logic [15:0] payload_len;
        logic [31:0] peer_ip;
        logic [31:0] seq;
        logic [15:0] sender_port;
        logic [7:0]  attempt_id;
        logic [31:0] tsval;
        logic [31:0] now_ms;
    } mid_item_t;

    typedef struct packed {
        logic [3:0]  action;
        logic        ack_valid;
        logic [31:0] ack_dest_ip;
        logic [15:0] ack_dest_port;
        logic [31:0] ack_seq;
        logic [15:0] ack_source_port;
        logic [1:0]  ack_flags;
        logic [7:0]  ack_attempt_id;
        logic [31:0] ack_tsval;
        logic [31:0] ack_tsecr;
        logic [15:0] ack_checksum;
        logic [15:0] deliver_len;
    } result_t;

    // ones'-complement sum over the eleven header words, checksum word as zero
    function automatic logic [15:0] hdr_csum(
        input logic [31:0] seq,
        input logic [15:0] port,
        input logic [15:0] flags,
        input logic [7:0]  rid,
        input logic [7:0]  resv,
        input logic [15:0] win,
        input logic [31:0] tsv,
        input logic [31:0] tse
    );
        logic [19:0] sum;
        logic [16:0] fold1;
        logic [15:0] fold2;
        sum = 20'(seq[31:16]) + 20'(seq[15:0]) + 20'(port) + 20'(flags)
            + 20'({rid, resv}) + 20'(win) + 20'(tsv[31:16]) + 20'(tsv[15:0])
            + 20'(tse[31:16]) + 20'(tse[15:0]);
        fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        return ~fold2;
    endfunction

endpackage

/* design/saw_fifo.sv */
// Small register queue with push/pop handshake, used between the stages and for the results.
module saw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/saw_front.sv */
// Front stage: checks length and header checksum and classifies the flags of each word.
module saw_front (
    input  logic                 push,
    input  logic                 mid_full,
    input  logic [15:0]          frame_len,
    input  logic [31:0]          peer_ip,
    input  logic [31:0]          header_seq,
    input  logic [15:0]          sender_port,
    input  logic [15:0]          header_flags,
    input  logic [7:0]           attempt_id,
    input  logic [7:0]           reserved_byte,
    input  logic [15:0]          window_field,
    input  logic [15:0]          header_checksum,
    input  logic [31:0]          sender_tsval,
    input  logic [31:0]          sender_tsecr,
    input  logic [31:0]          now_ms,
    output logic                 mid_wr,
    output saw_pkg::mid_item_t   item
);

    import saw_pkg::*;

    logic [15:0] calc_csum;

    assign calc_csum = hdr_csum(header_seq, sender_port, header_flags, attempt_id,
                                reserved_byte, window_field, sender_tsval, sender_tsecr);

    assign mid_wr = push && !mid_full;

    always_comb
    begin
        item.frame_ok    = (frame_len >= HDR_BYTES) && (calc_csum == header_checksum);
        item.is_syn      = header_flags[FLAG_SYN_BIT];
        item.is_start    = header_flags[FLAG_START_BIT];
        item.is_data     = header_flags[FLAG_DATA_BIT];
        item.is_fin      = header_flags[FLAG_FIN_BIT];
        item.payload_len = frame_len - HDR_BYTES;
        item.peer_ip     = peer_ip;
        item.seq         = header_seq;
        item.sender_port = sender_port;
        item.attempt_id  = attempt_id;
        item.tsval       = sender_tsval;
        item.now_ms      = now_ms;
    end

endmodule

/* design/saw_back.sv */
// Back stage: applies the receiver state to each classified word and builds the ACK.
module saw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  saw_pkg::mid_item_t item,
    input  logic               mid_empty,
    input  logic               out_full,
    input  logic [15:0]        own_port,
    output logic               mid_pop,
    output logic               res_wr,
    output saw_pkg::result_t   res
);

    import saw_pkg::*;

    logic        started_reg, started_next;
    logic        finished_reg, finished_next;
    logic [31:0] last_reg, last_next;

    logic [3:0]  action;
    logic        ack;
    logic [31:0] aseq;
    logic [1:0]  aflags;
    logic [15:0] dlen;
    logic [15:0] ack_csum;

    assign mid_pop = !mid_empty && !out_full;
    assign res_wr  = mid_pop;

    always_comb
    begin
        action        = ACT_OTHER;
        ack           = 1'b0;
        aseq          = item.seq;
        aflags        = ACK_FLAGS_PLAIN;
        dlen          = '0;
        started_next  = started_reg;
        finished_next = finished_reg;
        last_next     = last_reg;
        priority if (finished_reg)
        begin
            action = ACT_AFTER_FINISH;
        end
        else if (!item.frame_ok)
        begin
            action = ACT_INVALID;
        end
        else if (item.is_syn)
        begin
            action = ACT_SYNACK;
            ack    = 1'b1;
            aseq   = '0;
            aflags = ACK_FLAGS_SYNACK;
        end
        else if (item.is_start)
        begin
            action       = ACT_START;
            started_next = 1'b1;
        end
        else if (!started_reg && (item.is_data || item.is_fin))
        begin
            action = ACT_EARLY_ACK;
            ack    = 1'b1;
            if (item.is_fin)
            begin
                finished_next = 1'b1;
            end
        end
        else if (item.is_data)
        begin
            priority if (item.seq == last_reg + 32'd1)
            begin
                action    = ACT_DELIVERED;
                ack       = 1'b1;
                dlen      = item.payload_len;
                last_next = item.seq;
            end
            else if (item.seq == last_reg)
            begin
                action = ACT_DUPLICATE;
                ack    = 1'b1;
            end
            else
            begin
                action = ACT_OUT_OF_ORDER;
            end
        end
        else if (item.is_fin)
        begin
            action        = ACT_FIN;
            ack           = 1'b1;
            finished_next = 1'b1;
        end
    end

    assign ack_csum = hdr_csum(aseq, own_port, {14'd0, aflags}, item.attempt_id,
                               ACK_RESERVED, ACK_WINDOW, item.now_ms, item.tsval);

    always_comb
    begin
        res                = '0;
        res.action         = action;
        res.deliver_len    = dlen;
        if (ack)
        begin
            res.ack_valid       = 1'b1;
            res.ack_dest_ip     = item.peer_ip;
            res.ack_dest_port   = item.sender_port;
            res.ack_seq         = aseq;
            res.ack_source_port = own_port;
            res.ack_flags       = aflags;
            res.ack_attempt_id  = item.attempt_id;
            res.ack_tsval       = item.now_ms;
            res.ack_tsecr       = item.tsval;
            res.ack_checksum    = ack_csum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            last_reg     <= '0;
        end
        else if (mid_pop)
        begin
            started_reg  <= started_next;
            finished_reg <= finished_next;
            last_reg     <= last_next;
        end
    end

endmodule

/* design/stop_and_wait_multicast_ack_receiver.sv */
// Top level of the stop-and-wait multicast ACK receiver: queues, front and back stages.
// Takes one received header word per cycle while full is low and returns exactly one result word
// per accepted header, in order. A pushed word passes through the mid queue and then the result
// queue: the front stage checks length and header checksum in the accept cycle and writes a small
// queue, and the back stage updates the started/finished/sequence state and builds the ACK with
// its checksum into the result queue. Throughput is one word per cycle while results are popped;
// full rises only when both queues are backed up by a stalled pop. The receiver's own port is
// written through cfg_wen and cfg_wdata and should only change while no words are in flight.
module stop_and_wait_multicast_ack_receiver #(
    parameter int MID_DEPTH = saw_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = saw_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [15:0] frame_len,
    input  logic [31:0] peer_ip,
    input  logic [31:0] header_seq,
    input  logic [15:0] sender_port,
    input  logic [15:0] header_flags,
    input  logic [7:0]  attempt_id,
    input  logic [7:0]  reserved_byte,
    input  logic [15:0] window_field,
    input  logic [15:0] header_checksum,
    input  logic [31:0] sender_tsval,
    input  logic [31:0] sender_tsecr,
    input  logic [31:0] now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  action,
    output logic        ack_valid,
    output logic [31:0] ack_dest_ip,
    output logic [15:0] ack_dest_port,
    output logic [31:0] ack_seq,
    output logic [15:0] ack_source_port,
    output logic [1:0]  ack_flags,
    output logic [7:0]  ack_attempt_id,
    output logic [31:0] ack_tsval,
    output logic [31:0] ack_tsecr,
    output logic [15:0] ack_checksum,
    output logic [15:0] deliver_len
);

    import saw_pkg::*;

    logic [15:0] own_port_reg;

    mid_item_t   front_item;
    mid_item_t   mid_head;
    logic        mid_wr, mid_pop, mid_full, mid_empty;
    result_t     back_res;
    result_t     out_head;
    logic        res_wr, out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_port_reg <= '0;
        end
        else if (cfg_wen)
        begin
            own_port_reg <= cfg_wdata;
        end
    end

    saw_front u_front (
        .push            (push),
        .mid_full        (mid_full),
        .frame_len       (frame_len),
        .peer_ip         (peer_ip),
        .header_seq      (header_seq),
        .sender_port     (sender_port),
        .header_flags    (header_flags),
        .attempt_id      (attempt_id),
        .reserved_byte   (reserved_byte),
        .window_field    (window_field),
        .header_checksum (header_checksum),
        .sender_tsval    (sender_tsval),
        .sender_tsecr    (sender_tsecr),
        .now_ms          (now_ms),
        .mid_wr          (mid_wr),
        .item            (front_item)
    );

    saw_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (front_item),
        .rd_en   (mid_pop),
        .rd_data (mid_head),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    saw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_head),
        .mid_empty  (mid_empty),
        .out_full   (out_full),
        .own_port   (own_port_reg),
        .mid_pop    (mid_pop),
        .res_wr     (res_wr),
        .res        (back_res)
    );

    saw_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (out_head),
        .full    (out_full),
        .empty   (empty)
    );

    assign full            = mid_full;
    assign action          = out_head.action;
    assign ack_valid       = out_head.ack_valid;
    assign ack_dest_ip     = out_head.ack_dest_ip;
    assign ack_dest_port   = out_head.ack_dest_port;
    assign ack_seq         = out_head.ack_seq;
    assign ack_source_port = out_head.ack_source_port;
    assign ack_flags       = out_head.ack_flags;
    assign ack_attempt_id  = out_head.ack_attempt_id;
    assign ack_tsval       = out_head.ack_tsval;
    assign ack_tsecr       = out_head.ack_tsecr;
    assign ack_checksum    = out_head.ack_checksum;
    assign deliver_len     = out_head.deliver_len;

    a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> !out_full)
        else $error("result written into a full queue");

    a_quiet_when_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr && !back_res.ack_valid) |->
            (back_res.ack_dest_ip == '0 && back_res.ack_checksum == '0 &&
             back_res.ack_flags == '0))
        else $error("ACK fields set without an ACK");

    a_len_only_on_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr && back_res.action != ACT_DELIVERED) |-> back_res.deliver_len == '0)
        else $error("payload length reported without delivery");

    a_out_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_head)))
        else $error("waiting result changed under stall");

endmodule
